### rtl/core/sbip_pkg.sv
// Shared types and constants for the interpolating sample player.
// Holds the request/result structs, code enums and fixed widths.
// Used by sbip_interp and the top level; sbip_ram has no package dependency.
package sbip_pkg;

    localparam int MAX_LENGTH  = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(MAX_LENGTH);
    localparam int POS_W       = ADDR_W + 1;
    localparam int STEP_W      = 24;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int ACC_W       = DIFF_W + FRAC_BITS + 1;
    localparam int PSUM_W      = POS_W + FRAC_BITS + 1;

    typedef enum logic [2:0] {
        REQ_WRITE_AT  = 3'd0,
        REQ_READ_AT   = 3'd1,
        REQ_PUSH_BACK = 3'd2,
        REQ_READ_NEXT = 3'd3,
        REQ_STRETCH   = 3'd4,
        REQ_REWIND    = 3'd5
    } t_req_code;

    typedef struct packed {
        logic [2:0]                    req_type;
        logic [ADDR_W-1:0]             sample_index;
        logic signed [SAMPLE_BITS-1:0] write_sample;
        logic [STEP_W-1:0]             step_factor;
    } t_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] read_sample;
        logic [POS_W-1:0]              play_position;
        logic                          at_end;
        logic                          accepted;
    } t_rsp;

    // What an accepted request turns into after the bounds checks
    typedef enum logic [2:0] {
        K_NONE,
        K_WRITE,
        K_PUSH,
        K_READ,
        K_STEP,
        K_INTERP,
        K_REWIND
    } t_kind;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_LOAD,
        ALU_DIFF,
        ALU_MUL
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIFF,
        S_MUL,
        S_SUM
    } t_state;

endpackage

### rtl/core/sbip_ram.sv
// Single-port-write, single-port-read sample store with registered read data.
// Generic; no package dependency.
module sbip_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/sbip_interp.sv
// Shared interpolation unit: subtract, multiply by fraction, then add back.
// One operation per cycle under control of the sequencer; depends on sbip_pkg.
module sbip_interp
    import sbip_pkg::*;
(
    input  logic                          i_clk,
    input  t_alu_op                       i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [FRAC_BITS-1:0]          i_frac,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [DIFF_W-1:0]      w_diff;
    logic signed [DIFF_W-1:0]      w_mul_in;
    logic signed [FRAC_BITS:0]     w_frac;
    logic signed [ACC_W-1:0]       w_prod;

    assign w_diff   = {i_sample[SAMPLE_BITS-1], i_sample} - {r_a[SAMPLE_BITS-1], r_a};
    assign w_mul_in = r_acc[DIFF_W-1:0];
    assign w_frac   = {1'b0, i_frac};
    assign w_prod   = w_mul_in * w_frac;

    always_ff @(posedge i_clk) begin
        case (i_op)
            ALU_LOAD: r_a   <= i_sample;
            ALU_DIFF: r_acc <= ACC_W'(w_diff);
            ALU_MUL:  r_acc <= w_prod;
            default: ;
        endcase
    end

    // Taking bits above the fraction floors the product; the result lies
    // between both samples, so the wrap of the narrow add never shows
    assign o_result = r_a + r_acc[FRAC_BITS +: SAMPLE_BITS];

endmodule

### rtl/core/sample_buffer_interpolating_player.sv
// Top level of the interpolating sample player: sequencer, position and length
// registers, result register. Uses sbip_pkg, sbip_ram and sbip_interp.
//
//  channel   | signals                     | transfer
//  ----------+-----------------------------+-------------------------------
//  request   | start, busy, i_req          | start high while busy low
//  result    | o_valid, o_rsp              | one cycle, o_valid high
//  config    | i_cfg_we, i_cfg_wdata       | i_cfg_we high
//
//  Write, push-back, rewind and ignored requests finish when accepted;
//  read-at, read-next and the end cases of stretch pass through S_FETCH;
//  an interpolating stretch runs S_FETCH, S_DIFF, S_MUL and S_SUM for the registered
//  two-sample store read, then subtract and multiply in the shared unit.
//  Reset (synchronous, i_rst_n low) clears the position, sets the used length
//  to the store depth; the store itself is not cleared.
//  The result cannot be stalled; busy drops in the cycle the result shows.
module sample_buffer_interpolating_player
    import sbip_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_valid,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_wdata
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LENGTH);

    t_state                  r_state, n_state;
    t_kind                   r_kind, dec_kind;
    logic [STEP_W-1:0]       r_step;
    logic [POS_W-1:0]        r_used_len;
    logic [POS_W-1:0]        r_pos_idx, n_pos_idx;
    logic [FRAC_BITS-1:0]    r_pos_frac, n_pos_frac;
    logic                    r_valid;
    t_rsp                    r_rsp, n_rsp;

    logic                    w_accept;
    logic [ADDR_W-1:0]       dec_raddr;
    logic                    w_addr_ok, w_pos_ok;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr, w_raddr;
    logic [SAMPLE_BITS-1:0]  w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_interp;
    t_alu_op                 w_alu_op;
    logic                    w_finish;
    logic [PSUM_W-1:0]       w_pos_sum;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    assign w_addr_ok = {1'b0, i_req.sample_index} < r_used_len;
    assign w_pos_ok  = r_pos_idx < r_used_len;

    // Bounds checks on the incoming request
    always_comb begin
        dec_kind  = K_NONE;
        dec_raddr = r_pos_idx[ADDR_W-1:0];
        case (i_req.req_type)
            REQ_WRITE_AT: begin
                if (w_addr_ok) dec_kind = K_WRITE;
            end
            REQ_READ_AT: begin
                dec_raddr = i_req.sample_index;
                if (w_addr_ok) dec_kind = K_READ;
            end
            REQ_PUSH_BACK: begin
                if (w_pos_ok) dec_kind = K_PUSH;
            end
            REQ_READ_NEXT: begin
                if (w_pos_ok) dec_kind = K_STEP;
            end
            REQ_STRETCH: begin
                if (r_used_len == POS_W'(1)) begin
                    // single entry: return entry zero, position stays
                    dec_kind  = K_READ;
                    dec_raddr = '0;
                end else if (r_used_len != '0) begin
                    if (r_pos_idx < r_used_len - POS_W'(1)) begin
                        dec_kind = K_INTERP;
                    end else if (r_pos_idx == r_used_len - POS_W'(1)) begin
                        dec_kind = K_STEP;
                    end
                end
            end
            REQ_REWIND: dec_kind = K_REWIND;
            default: dec_kind = K_NONE;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (dec_kind inside {K_READ, K_STEP, K_INTERP})) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = (r_kind == K_INTERP) ? S_DIFF : S_IDLE;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_pos_sum = {1'b0, r_pos_idx, r_pos_frac} + PSUM_W'(r_step);

    // Datapath control and result values
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = i_req.sample_index;
        w_raddr    = r_pos_idx[ADDR_W-1:0] + ADDR_W'(1);
        w_alu_op   = ALU_IDLE;
        w_finish   = 1'b0;
        n_pos_idx  = r_pos_idx;
        n_pos_frac = r_pos_frac;
        n_rsp      = '0;
        case (r_state)
            S_IDLE: begin
                w_raddr = dec_raddr;
                if (w_accept) begin
                    w_we = (dec_kind == K_WRITE) || (dec_kind == K_PUSH);
                    if (dec_kind == K_PUSH) begin
                        w_waddr = r_pos_idx[ADDR_W-1:0];
                    end
                    w_finish = !(dec_kind inside {K_READ, K_STEP, K_INTERP});
                    n_rsp.accepted = (dec_kind != K_NONE);
                    if (dec_kind == K_PUSH) begin
                        n_pos_idx  = r_pos_idx + POS_W'(1);
                        n_pos_frac = '0;
                    end else if (dec_kind == K_REWIND) begin
                        n_pos_idx  = '0;
                        n_pos_frac = '0;
                    end
                end
            end
            S_FETCH: begin
                if (r_kind == K_INTERP) begin
                    w_alu_op = ALU_LOAD;
                end else begin
                    w_finish          = 1'b1;
                    n_rsp.read_sample = w_rdata;
                    n_rsp.accepted    = 1'b1;
                    if (r_kind == K_STEP) begin
                        n_pos_idx  = r_pos_idx + POS_W'(1);
                        n_pos_frac = '0;
                    end
                end
            end
            S_DIFF: w_alu_op = ALU_DIFF;
            S_MUL:  w_alu_op = ALU_MUL;
            S_SUM: begin
                w_finish          = 1'b1;
                n_rsp.read_sample = w_interp;
                n_rsp.accepted    = 1'b1;
                // saturate the integer part at the store depth
                if (w_pos_sum[PSUM_W-1:FRAC_BITS] > (POS_W + 1)'(MAX_LENGTH)) begin
                    n_pos_idx  = MAX_POS;
                    n_pos_frac = '0;
                end else begin
                    n_pos_idx  = w_pos_sum[FRAC_BITS +: POS_W];
                    n_pos_frac = w_pos_sum[FRAC_BITS-1:0];
                end
            end
            default: ;
        endcase
        n_rsp.play_position = n_pos_idx;
        n_rsp.at_end        = (r_used_len == '0) || (n_pos_idx >= r_used_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos_idx  <= '0;
            r_pos_frac <= '0;
            r_used_len <= MAX_POS;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_finish;
            if (w_finish) begin
                r_pos_idx  <= n_pos_idx;
                r_pos_frac <= n_pos_frac;
            end
            if (i_cfg_we) begin
                r_used_len <= (i_cfg_wdata > MAX_POS) ? MAX_POS : i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= dec_kind;
            r_step <= i_req.step_factor;
        end
        if (w_finish) begin
            r_rsp <= n_rsp;
        end
    end

    sbip_ram #(
        .DEPTH (MAX_LENGTH),
        .WIDTH (SAMPLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_req.write_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sbip_interp u_interp (
        .i_clk    (i_clk),
        .i_op     (w_alu_op),
        .i_sample (w_rdata),
        .i_frac   (r_pos_frac),
        .o_result (w_interp)
    );

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // The result strobe only ever comes with the sequencer back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    // Rewind answers in the next cycle at position zero
    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_REWIND)
        |=> (o_valid && o_rsp.accepted && o_rsp.play_position == '0))
        else $error("rewind result wrong");

    // Reported position never passes the store depth
    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.play_position <= MAX_POS))
        else $error("position beyond store depth");

    // Not at end means the position lies inside the used length
    a_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.at_end) |-> (o_rsp.play_position < r_used_len))
        else $error("at_end flag inconsistent with position");

endmodule
